FILE: hw/rtl/bdx_pkg.sv
// Shared widths, constants and handoff types for the 2x2 box downscaler.
package bdx_pkg;

    localparam int PIXEL_W     = 8;
    localparam int PAIR_W      = 9;
    localparam int SUM_W       = 10;
    localparam int CFG_W       = 10;
    localparam int PAIRS_RESET = 200;

    typedef struct packed {
        logic              issue;
        logic              last;
        logic [PAIR_W-1:0] pair;
    } pair_req_t;

endpackage

FILE: hw/rtl/bdx_line_mem.sv
// Line buffer of pair sums: one write port, one registered read port.
module bdx_line_mem #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/bdx_pair_ctrl.sv
// Column/row tracking, pair summing and line buffer access control.
module bdx_pair_ctrl
    import bdx_pkg::*;
#(
    parameter int MAX_PAIRS = 512,
    parameter int IDX_W     = 9
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic [CFG_W-1:0]   pairs_per_row,
    output logic               mem_we,
    output logic               mem_re,
    output logic [IDX_W-1:0]   mem_addr,
    output logic [PAIR_W-1:0]  mem_wdata,
    output pair_req_t          req
);

    localparam int CNT_W = $clog2(MAX_PAIRS + 1);
    localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;

    logic [IDX_W-1:0]   pair_index_reg, pair_index_next;
    logic               odd_column_reg, odd_column_next;
    logic               odd_row_reg, odd_row_next;
    logic [PIXEL_W-1:0] left_pixel_reg, left_pixel_next;

    logic [CMP_W-1:0]  cfg_ext;
    logic [CMP_W-1:0]  eff;
    logic [CMP_W-1:0]  idx_plus;
    logic              last;
    logic              complete;
    logic [PAIR_W-1:0] pair;

    always_comb
    begin
        cfg_ext = CMP_W'(pairs_per_row);
        if (cfg_ext == '0)
        begin
            eff = CMP_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_PAIRS))
        begin
            eff = CMP_W'(MAX_PAIRS);
        end
        else
        begin
            eff = cfg_ext;
        end
        idx_plus = CMP_W'(pair_index_reg) + CMP_W'(1);
        last     = (idx_plus >= eff);
        pair     = PAIR_W'(left_pixel_reg) + PAIR_W'(pixel);
        complete = accept && odd_column_reg;
    end

    always_comb
    begin
        pair_index_next = pair_index_reg;
        odd_column_next = odd_column_reg;
        odd_row_next    = odd_row_reg;
        left_pixel_next = left_pixel_reg;
        if (accept)
        begin
            if (!odd_column_reg)
            begin
                left_pixel_next = pixel;
                odd_column_next = 1'b1;
            end
            else
            begin
                odd_column_next = 1'b0;
                if (last)
                begin
                    pair_index_next = '0;
                    odd_row_next    = !odd_row_reg;
                end
                else
                begin
                    pair_index_next = pair_index_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_index_reg <= '0;
            odd_column_reg <= 1'b0;
            odd_row_reg    <= 1'b0;
        end
        else
        begin
            pair_index_reg <= pair_index_next;
            odd_column_reg <= odd_column_next;
            odd_row_reg    <= odd_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_pixel_reg <= left_pixel_next;
    end

    assign mem_we    = complete && !odd_row_reg;
    assign mem_re    = complete && odd_row_reg;
    assign mem_addr  = pair_index_reg;
    assign mem_wdata = pair;

    assign req.issue = mem_re;
    assign req.last  = last;
    assign req.pair  = pair;

    a_no_we_re: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("line buffer written and read in one cycle");

    a_row_flip: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(odd_row_reg) |-> $past(complete && last))
        else $error("row parity changed without a last pair");

    a_index_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        complete && last |=> pair_index_reg == '0)
        else $error("pair index did not wrap at row end");

endmodule

FILE: hw/rtl/bdx_out_stage.sv
// Read-data alignment stage, 2x2 sum and output word register.
module bdx_out_stage
    import bdx_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  pair_req_t          req,
    input  logic [PAIR_W-1:0]  rdata,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [PIXEL_W-1:0] out_pixel,
    output logic               row_end,
    output logic               busy
);

    logic               s1_valid_reg, s1_valid_next;
    logic               s1_last_reg;
    logic [PAIR_W-1:0]  s1_pair_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               row_end_reg;

    logic             out_free;
    logic             s1_move;
    logic [SUM_W-1:0] total;

    always_comb
    begin
        out_free       = !out_valid_reg || out_ready;
        s1_move        = s1_valid_reg && out_free;
        busy           = s1_valid_reg && !out_free;
        total          = SUM_W'(rdata) + SUM_W'(s1_pair_reg);
        s1_valid_next  = req.issue || (s1_valid_reg && !out_free);
        out_valid_next = s1_move || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.issue)
        begin
            s1_pair_reg <= req.pair;
            s1_last_reg <= req.last;
        end
        if (s1_move)
        begin
            out_pixel_reg <= total[SUM_W-1:2];
            row_end_reg   <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign row_end   = row_end_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        req.issue |-> !busy)
        else $error("read issued while stage blocked");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output word without a pending sum");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> s1_valid_reg)
        else $error("pending sum dropped while stalled");

endmodule

FILE: hw/rtl/box_downscale_2x2_unit.sv
// Top level of the 2x2 box-filter image downscaler.
//
//  channel  signals                          direction
//  -------  -------------------------------  ---------
//  cfg      cfg_valid cfg_ready cfg_data     in  (pairs per row)
//  in       in_valid in_ready pixel          in  (raster pixels)
//  out      out_valid out_ready out_pixel    out (one word per 2x2 block)
//           row_end
//
//  One pixel per cycle is taken while in_ready is high; the output word for a
//  block closed on an odd row is read from the line buffer, then added and registered.
//  in_ready drops only while a pending sum and the output word are both
//  stalled by out_ready. Reset clears counters and valids; the line buffer
//  is not cleared and the row width returns to 200 pairs.
module box_downscale_2x2_unit
    import bdx_pkg::*;
#(
    parameter int MAX_PAIRS = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIXEL_W-1:0] pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PIXEL_W-1:0] out_pixel,
    output logic               row_end
);

    localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    logic [CFG_W-1:0]  pairs_per_row_reg, pairs_per_row_next;
    logic              accept;
    logic              busy;
    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;
    logic [PAIR_W-1:0] mem_wdata;
    logic [PAIR_W-1:0] mem_rdata;
    pair_req_t         req;

    assign cfg_ready = 1'b1;
    assign in_ready  = !busy;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        pairs_per_row_next = pairs_per_row_reg;
        if (cfg_valid && cfg_ready)
        begin
            pairs_per_row_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_per_row_reg <= CFG_W'(PAIRS_RESET);
        end
        else
        begin
            pairs_per_row_reg <= pairs_per_row_next;
        end
    end

    bdx_pair_ctrl #(
        .MAX_PAIRS (MAX_PAIRS),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .pixel         (pixel),
        .pairs_per_row (pairs_per_row_reg),
        .mem_we        (mem_we),
        .mem_re        (mem_re),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .req           (req)
    );

    bdx_line_mem #(
        .DEPTH  (MAX_PAIRS),
        .ADDR_W (IDX_W),
        .DATA_W (PAIR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    bdx_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rdata     (mem_rdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_pixel (out_pixel),
        .row_end   (row_end),
        .busy      (busy)
    );

endmodule
